@@ rtl/tsd_pkg.sv @@
`default_nettype none

package tsd_pkg;

    localparam int SIDE_DEPTH = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(SIDE_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int KIND_W     = 3;
    localparam int INDEX_W    = 11;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [CNT_W-1:0] SIDE_FULL = CNT_W'(SIDE_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_READ_INDEX = 3'd2,
        KIND_WRITE_INDEX = 3'd3,
        KIND_FRONT      = 3'd4,
        KIND_BACK       = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_READ_INDEX,
        OP_WRITE_INDEX,
        OP_FRONT,
        OP_BACK
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } rsp_t;

    typedef struct packed {
        op_t                      op;
        logic [INDEX_W-1:0]       index;
        logic [DATA_WIDTH-1:0]    value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_pop_t;

endpackage

`default_nettype wire

@@ rtl/two_stack_deque_engine.sv @@
// Double-ended buffer engine kept as two stacks of 1024 words each.
// Request channel: req_valid / req_stall with one req word (kind, index,
// value). Kinds: push front, push back, read at index, write at index,
// read front, read back. Unknown kinds pass through with status ok.
// Response channel: rsp_valid / rsp_stall with one rsp word per request
// (data, status, count, is_empty), in request order.
// A word moves when valid is high and stall is low at a rising edge.
// Each accepted request passes the front register, the command queue and
// the back stage with its registered memory read before its response shows.
// Throughput: one request per cycle while the response side keeps taking;
// each reads both stack memories, writes at most one entry and the counters.
// When the response side stalls, the result word holds, the two-entry
// queue fills and req_stall rises once the front register backs up.
// Reset (rst_n low, asynchronous) empties both stacks by clearing the
// counters; stack memory contents are not cleared and need no sweep.
`default_nettype none

module two_stack_deque_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire tsd_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output tsd_pkg::rsp_t       rsp
);

    tsd_pkg::cmd_push_t push;
    tsd_pkg::cmd_pop_t  head;
    logic               queue_full;
    logic               pop;

    tsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push       (push),
        .queue_full (queue_full)
    );

    tsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    tsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/tsd_front.sv @@
`default_nettype none

module tsd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire tsd_pkg::req_t    req,
    output tsd_pkg::cmd_push_t    push,
    input  wire logic             queue_full
);

    logic           valid_reg;
    logic           valid_next;
    tsd_pkg::cmd_t  cmd_reg;
    tsd_pkg::cmd_t  cmd_next;
    logic           take;
    logic           pushed;

    assign pushed    = valid_reg && !queue_full;
    assign req_stall = valid_reg && queue_full;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_next.index = req.index;
        cmd_next.value = req.value[tsd_pkg::DATA_WIDTH-1:0];
        unique case (req.kind)
            tsd_pkg::KIND_PUSH_FRONT:  cmd_next.op = tsd_pkg::OP_PUSH_FRONT;
            tsd_pkg::KIND_PUSH_BACK:   cmd_next.op = tsd_pkg::OP_PUSH_BACK;
            tsd_pkg::KIND_READ_INDEX:  cmd_next.op = tsd_pkg::OP_READ_INDEX;
            tsd_pkg::KIND_WRITE_INDEX: cmd_next.op = tsd_pkg::OP_WRITE_INDEX;
            tsd_pkg::KIND_FRONT:       cmd_next.op = tsd_pkg::OP_FRONT;
            tsd_pkg::KIND_BACK:        cmd_next.op = tsd_pkg::OP_BACK;
            default:                   cmd_next.op = tsd_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pushed)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push.valid = valid_reg;
    assign push.cmd   = cmd_reg;

endmodule

`default_nettype wire

@@ rtl/tsd_queue.sv @@
`default_nettype none

module tsd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tsd_pkg::cmd_push_t push,
    output logic                    full,
    output tsd_pkg::cmd_pop_t       head,
    input  wire logic               pop
);

    tsd_pkg::cmd_t               entry_reg [tsd_pkg::QUEUE_DEPTH];
    logic [tsd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [tsd_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [tsd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [tsd_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [tsd_pkg::QCNT_W-1:0]  fill_reg;
    logic [tsd_pkg::QCNT_W-1:0]  fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign full     = (fill_reg == tsd_pkg::QCNT_W'(tsd_pkg::QUEUE_DEPTH));
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && head.valid;
    assign head.valid = (fill_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsd_back.sv @@
`default_nettype none

module tsd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tsd_pkg::cmd_pop_t head,
    output logic                   pop,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tsd_pkg::rsp_t          rsp
);

    localparam int AW = tsd_pkg::ADDR_W;
    localparam int CW = tsd_pkg::CNT_W;
    localparam int DW = tsd_pkg::DATA_WIDTH;

    logic [DW-1:0] front_mem [tsd_pkg::SIDE_DEPTH];
    logic [DW-1:0] back_mem  [tsd_pkg::SIDE_DEPTH];

    logic [CW-1:0]  fc_reg;
    logic [CW-1:0]  fc_next;
    logic [CW-1:0]  bc_reg;
    logic [CW-1:0]  bc_next;

    logic                       valid_reg;
    logic                       valid_next;
    tsd_pkg::status_t           status_reg;
    tsd_pkg::status_t           status_next;
    logic [tsd_pkg::COUNT_W-1:0] count_reg;
    logic [tsd_pkg::COUNT_W-1:0] count_next;
    logic                       use_mem_reg;
    logic                       use_mem_next;
    logic                       from_front_reg;
    logic                       from_front_next;
    logic [DW-1:0]              front_rd_reg;
    logic [DW-1:0]              back_rd_reg;

    logic           issue;
    logic           f_we;
    logic           b_we;
    logic [AW-1:0]  f_addr;
    logic [AW-1:0]  b_addr;
    logic [CW-1:0]  back_idx;
    logic [CW-1:0]  front_idx;
    logic           in_front;
    logic           in_back;
    tsd_pkg::cmd_t  cmd;

    assign cmd   = head.cmd;
    assign issue = head.valid && (!valid_reg || !rsp_stall);
    assign pop   = issue;

    assign in_front  = CW'(cmd.index) < fc_reg;
    assign back_idx  = CW'(cmd.index) - fc_reg;
    assign in_back   = !in_front && (back_idx < bc_reg);
    assign front_idx = fc_reg - CW'(1) - CW'(cmd.index);

    always_comb
    begin
        fc_next         = fc_reg;
        bc_next         = bc_reg;
        f_we            = 1'b0;
        b_we            = 1'b0;
        f_addr          = '0;
        b_addr          = '0;
        status_next     = tsd_pkg::ST_OK;
        use_mem_next    = 1'b0;
        from_front_next = 1'b0;
        unique case (cmd.op)
            tsd_pkg::OP_PUSH_FRONT:
            begin
                if (fc_reg == tsd_pkg::SIDE_FULL)
                begin
                    status_next = tsd_pkg::ST_FULL;
                end
                else
                begin
                    f_we    = 1'b1;
                    f_addr  = fc_reg[AW-1:0];
                    fc_next = fc_reg + CW'(1);
                end
            end
            tsd_pkg::OP_PUSH_BACK:
            begin
                if (bc_reg == tsd_pkg::SIDE_FULL)
                begin
                    status_next = tsd_pkg::ST_FULL;
                end
                else
                begin
                    b_we    = 1'b1;
                    b_addr  = bc_reg[AW-1:0];
                    bc_next = bc_reg + CW'(1);
                end
            end
            tsd_pkg::OP_READ_INDEX,
            tsd_pkg::OP_WRITE_INDEX:
            begin
                f_addr = front_idx[AW-1:0];
                b_addr = back_idx[AW-1:0];
                if (in_front)
                begin
                    f_we            = (cmd.op == tsd_pkg::OP_WRITE_INDEX);
                    use_mem_next    = (cmd.op == tsd_pkg::OP_READ_INDEX);
                    from_front_next = 1'b1;
                end
                else if (in_back)
                begin
                    b_we         = (cmd.op == tsd_pkg::OP_WRITE_INDEX);
                    use_mem_next = (cmd.op == tsd_pkg::OP_READ_INDEX);
                end
                else
                begin
                    status_next = tsd_pkg::ST_RANGE;
                end
            end
            tsd_pkg::OP_FRONT:
            begin
                f_addr = fc_reg[AW-1:0] - AW'(1);
                b_addr = '0;
                if (fc_reg != '0)
                begin
                    use_mem_next    = 1'b1;
                    from_front_next = 1'b1;
                end
                else if (bc_reg != '0)
                begin
                    use_mem_next = 1'b1;
                end
                else
                begin
                    status_next = tsd_pkg::ST_EMPTY;
                end
            end
            tsd_pkg::OP_BACK:
            begin
                b_addr = bc_reg[AW-1:0] - AW'(1);
                f_addr = '0;
                if (bc_reg != '0)
                begin
                    use_mem_next = 1'b1;
                end
                else if (fc_reg != '0)
                begin
                    use_mem_next    = 1'b1;
                    from_front_next = 1'b1;
                end
                else
                begin
                    status_next = tsd_pkg::ST_EMPTY;
                end
            end
            tsd_pkg::OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
        count_next = tsd_pkg::COUNT_W'(fc_next) + tsd_pkg::COUNT_W'(bc_next);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (issue)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg    <= '0;
            bc_reg    <= '0;
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (issue)
            begin
                fc_reg    <= fc_next;
                bc_reg    <= bc_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            status_reg     <= status_next;
            use_mem_reg    <= use_mem_next;
            from_front_reg <= from_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && f_we)
        begin
            front_mem[f_addr] <= cmd.value;
        end
        if (issue)
        begin
            front_rd_reg <= front_mem[f_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && b_we)
        begin
            back_mem[b_addr] <= cmd.value;
        end
        if (issue)
        begin
            back_rd_reg <= back_mem[b_addr];
        end
    end

    assign rsp_valid    = valid_reg;
    assign rsp.data     = !use_mem_reg ? '0 :
                          (from_front_reg ? tsd_pkg::WORD_W'(front_rd_reg)
                                          : tsd_pkg::WORD_W'(back_rd_reg));
    assign rsp.status   = status_reg;
    assign rsp.count    = count_reg;
    assign rsp.is_empty = (count_reg == '0);

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= tsd_pkg::SIDE_FULL && bc_reg <= tsd_pkg::SIDE_FULL)
        else $error("stack count beyond depth");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == tsd_pkg::COUNT_W'(fc_reg) + tsd_pkg::COUNT_W'(bc_reg))
        else $error("reported count out of step with stacks");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status_reg != tsd_pkg::ST_OK |-> rsp.data == '0)
        else $error("nonzero data on error");

    a_issue_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> !issue)
        else $error("result overwritten while stalled");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        issue && cmd.op == tsd_pkg::OP_PUSH_FRONT && fc_reg != tsd_pkg::SIDE_FULL
        |=> fc_reg == $past(fc_reg) + CW'(1))
        else $error("front push did not advance count");

endmodule

`default_nettype wire
